// File: design/lsm_pkg.sv
// Shared types, widths, register indexes and helpers for the line substring matcher.
package lsm_pkg;

  localparam int CHAR_W   = 8;
  localparam int LINE_W   = 16;
  localparam int POS_W    = 12;
  localparam int CHARS_W  = 64;
  localparam int LEN_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int SLOT_W   = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_CHARS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CASE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LOCATION = 2'd3;

  // Search location codes
  localparam logic [1:0] LOC_BOTH   = 2'd0;
  localparam logic [1:0] LOC_LEFT   = 2'd1;
  localparam logic [1:0] LOC_RIGHT  = 2'd2;
  localparam logic [1:0] LOC_DIFFER = 2'd3;

  // One history slot as it moves down the chain
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] chr;
  } hist_t;

  // Per-transfer control broadcast to every cell
  typedef struct packed {
    logic take;       // a character is accepted this cycle
    logic flush;      // zero byte: empty the whole history
    logic fold_case;  // ASCII case folding on
  } cell_ctl_t;

  // Fold A..Z to lower case when enabled
  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                  input logic en);
    logic [CHAR_W-1:0] r;
    r = c;
    if (en && c >= 8'h41 && c <= 8'h5A) r = c + 8'h20;
    return r;
  endfunction

  // Select one needle byte by slot
  function automatic logic [CHAR_W-1:0] needle_byte(input logic [CHARS_W-1:0] chars,
                                                    input logic [SLOT_W-1:0] slot);
    return chars[{slot, 3'b000} +: CHAR_W];
  endfunction

endpackage

// File: design/lsm_cell.sv
// One history cell: holds a character, passes it on, compares its input to a needle byte.
module lsm_cell import lsm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctl_t         ctl,
  input  hist_t             din,
  input  logic [CHAR_W-1:0] needle,
  input  logic              needle_used,
  output hist_t             hist,
  output logic              hit
);

  // History slot: valid flag and character move together
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (ctl.take) begin
      hist.valid <= din.valid & ~ctl.flush;
      hist.chr   <= din.chr;
    end
  end

  // Compare the value this cell is about to hold
  assign hit = ~needle_used ||
               (din.valid &&
                fold_char(din.chr, ctl.fold_case) == fold_char(needle, ctl.fold_case));

endmodule

// File: design/line_substring_matcher.sv
// A match is registered and presented on m_tdata in the cycle after the character transfer ending it.
// Throughput: one character per cycle; the compare is one parallel pass over the cell chain.
// The input stalls only while a presented match is not taken (single output register).
// Reset (synchronous, rst high) clears configuration, history, line position and output valid.
// No clearing pass is needed after reset.
module line_substring_matcher import lsm_pkg::*; #(
  parameter int NEEDLE_MAX     = 8,
  parameter int LINE_CHARS_MAX = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  // s_tdata: char_byte[7:0], line_number[23:8]
  input  logic [23:0]          s_tdata,
  // s_tuser: file_side[0], line_begins[1], line_differs[2]
  input  logic [2:0]           s_tuser,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // m_tdata: match_line[15:0], match_position[27:16], zero fill[31:28]
  output logic [31:0]          m_tdata,
  // m_tuser: match_side[0]
  output logic [0:0]           m_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CHARS_W-1:0]   cfg_data
);

  localparam int PosCapInt = (LINE_CHARS_MAX - 1 > 4095) ? 4095 : LINE_CHARS_MAX - 1;
  localparam logic [POS_W-1:0] POS_CAP = POS_W'(PosCapInt);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(NEEDLE_MAX);

  // Configuration registers
  logic [CHARS_W-1:0] needle_chars;
  logic [LEN_W-1:0]   needle_length;
  logic               ignore_case;
  logic [1:0]         search_location;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_chars    <= '0;
      needle_length   <= '0;
      ignore_case     <= 1'b0;
      search_location <= LOC_BOTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NEEDLE_CHARS:    needle_chars    <= cfg_data;
        CFG_NEEDLE_LENGTH:   needle_length   <= cfg_data[LEN_W-1:0];
        CFG_IGNORE_CASE:     ignore_case     <= cfg_data[0];
        CFG_SEARCH_LOCATION: search_location <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Input fields
  logic [CHAR_W-1:0] char_byte;
  logic [LINE_W-1:0] line_number;
  logic              file_side, line_begins, line_differs;
  logic              accept;

  assign char_byte    = s_tdata[7:0];
  assign line_number  = s_tdata[23:8];
  assign file_side    = s_tuser[0];
  assign line_begins  = s_tuser[1];
  assign line_differs = s_tuser[2];
  assign accept       = s_tvalid & s_tready;

  // Effective needle length
  logic [LEN_W-1:0] len;
  assign len = (needle_length > LEN_MAX) ? LEN_MAX : needle_length;

  // Line position counter
  logic [POS_W-1:0] pos, cur;
  assign cur = line_begins ? '0 : pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= (cur < POS_CAP) ? cur + 1'b1 : cur;
    end
  end

  // Cell chain
  cell_ctl_t             ctl;
  hist_t                 hist [NEEDLE_MAX];
  hist_t                 din  [NEEDLE_MAX];
  logic [NEEDLE_MAX-1:0] hits;
  logic [NEEDLE_MAX-1:0] hist_valid;

  assign ctl = '{take: accept, flush: (char_byte == '0), fold_case: ignore_case};

  for (genvar j = 0; j < NEEDLE_MAX; j++) begin : g_cell
    logic             used;
    logic [LEN_W-1:0] slot_full;

    // Cell j lines up with needle character len-1-j
    assign used      = (LEN_W'(j) < len);
    assign slot_full = len - LEN_W'(1) - LEN_W'(j);

    if (j == 0) begin : g_head
      assign din[j] = '{valid: 1'b1, chr: char_byte};
    end else begin : g_body
      assign din[j] = '{valid: hist[j-1].valid & ~line_begins, chr: hist[j-1].chr};
    end

    lsm_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .din         (din[j]),
      .needle      (needle_byte(needle_chars, slot_full[SLOT_W-1:0])),
      .needle_used (used),
      .hist        (hist[j]),
      .hit         (hits[j])
    );

    assign hist_valid[j] = hist[j].valid;
  end

  // Location filter
  logic eligible;
  always_comb begin
    case (search_location)
      LOC_BOTH:   eligible = 1'b1;
      LOC_LEFT:   eligible = ~file_side;
      LOC_RIGHT:  eligible = file_side;
      LOC_DIFFER: eligible = line_differs;
      default:    eligible = 1'b0;
    endcase
  end

  logic match;
  assign match = eligible && (len != '0) && (char_byte != '0) && (&hits);

  // Start offset of the match
  logic [POS_W-1:0] len_m1, start_pos;
  assign len_m1    = POS_W'(len) - POS_W'(1);
  assign start_pos = (cur >= POS_CAP || cur < len_m1) ? POS_CAP : cur - len_m1;

  // Output register
  logic             out_valid, out_side;
  logic [LINE_W-1:0] out_line;
  logic [POS_W-1:0]  out_pos;

  assign s_tready = ~out_valid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_tready) begin
      out_valid <= accept & match;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_side <= file_side;
      out_line <= line_number;
      out_pos  <= start_pos;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_pos, out_line};
  assign m_tuser  = out_side;

`ifndef SYNTHESIS
  a_empty_needle_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && needle_length == '0) |=> !m_tvalid)
    else $error("match reported with empty needle");

  a_zero_byte_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tdata[7:0] == 8'h00) |=> (!m_tvalid && hist_valid == '0))
    else $error("zero byte did not flush history or gave a match");

  a_line_start_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser[1]) |=> ($countones(hist_valid) <= 1 && pos <= 12'd1))
    else $error("line start did not clear history and position");

  a_pos_capped: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[27:16] <= POS_CAP)
    else $error("match position above cap");
`endif

endmodule
